// File: sv/smile_value_token_encoder_core_macros.svh
// Assertion helpers shared by the encoder RTL.
// Every check is clocked on clk and is off while rst_n is low.
`ifndef SMILE_VALUE_TOKEN_ENCODER_CORE_MACROS_SVH
`define SMILE_VALUE_TOKEN_ENCODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVTE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/svte_pkg.sv
package svte_pkg;

    localparam int unsigned TOKEN_MAX_BYTES = 11;
    localparam int unsigned TOKEN_IDX_W     = 4;
    localparam int unsigned VINT_MAX_GROUPS = 5;

    typedef enum logic [1:0] {
        MODE_INT        = 2'd0,
        MODE_DOUBLE     = 2'd1,
        MODE_TEXT_START = 2'd2,
        MODE_TEXT_CHAR  = 2'd3
    } mode_t;

    typedef logic [7:0] byte_t;

    localparam byte_t BYTE_SMALL_INT       = 8'hC0;
    localparam byte_t BYTE_VINT_PREFIX     = 8'h24;
    localparam byte_t BYTE_DOUBLE          = 8'h29;
    localparam byte_t BYTE_TEXT_EMPTY      = 8'h20;
    localparam byte_t BYTE_TEXT_SHORT_BASE = 8'h3F;
    localparam byte_t BYTE_TEXT_LONG       = 8'hE0;
    localparam byte_t BYTE_TEXT_END        = 8'hFC;
    localparam byte_t VINT_LAST_MARK       = 8'h80;

    localparam logic [30:0] INT_SATURATION = 31'h7FFF_FFFF;
    localparam logic [15:0] SHORT_TEXT_MAX = 16'd64;

    // One encoded token: bytes[0] goes out first, count is 1 to 11.
    typedef struct packed {
        byte_t [TOKEN_MAX_BYTES-1:0] bytes;
        logic [TOKEN_IDX_W-1:0]      count;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic long_open;
    } front_stat_t;

endpackage

// File: sv/svte_channel_if.sv
// Input channel: one value item per transaction.
interface svte_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] value_bits;
    logic [15:0] text_length;
    logic [7:0]  text_byte;
    logic        final_char;

    modport source (
        output valid, mode, value_bits, text_length, text_byte, final_char,
        input  ready
    );
    modport sink (
        input  valid, mode, value_bits, text_length, text_byte, final_char,
        output ready
    );
endinterface

// Output channel: one encoded byte per transaction.
interface svte_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       token_end;

    modport source (
        output valid, out_byte, token_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, token_end,
        output ready
    );
endinterface

// File: sv/smile_value_token_encoder_core.sv
// When the encoder is idle, the first byte of a token passes through the token queue,
// the back end's current-token register and the output register before it is offered.
// Throughput: one output byte per cycle while the receiver is ready; a token is 1 to 11
// bytes (11 for a double, 2 to 6 for a large integer), sent by the back end's serializer.
// Reset (rst_n, asynchronous, active low) empties the queue and output register and
// closes any open long string.
`include "smile_value_token_encoder_core_macros.svh"

// Smile value token encoder.
//
// The front end takes one item per transaction whenever the token queue has room and
// turns it into a complete token (up to eleven bytes plus a byte count) in the same
// cycle. It also owns the long-string flag, which is updated in item order as items
// are accepted, so the flag never has to wait for the back end.
//
// The queue decouples the two halves: the front end keeps accepting short items while
// the back end is still busy serializing a long token.
//
// The back end holds the token being sent and an index, and moves one byte per cycle,
// unless the output stalls, into an output register. When the last byte of a token
// moves out, the next token is taken from the queue in that same cycle, so single-byte
// tokens stream at full rate. token_end marks the last byte of each token.
module smile_value_token_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    svte_item_if.sink      item,
    svte_stream_if.source  stream
);

    logic                  push;
    logic                  pop;
    svte_pkg::token_t      push_data;
    svte_pkg::token_t      head;
    svte_pkg::queue_stat_t qstat;
    svte_pkg::front_stat_t fstat;

    svte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data),
        .fstat     (fstat)
    );

    svte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .stat      (qstat)
    );

    svte_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .stream (stream)
    );

    // A token is never written into a full queue.
    `SVTE_ASSERT_SAME(a_no_push_when_full, push, !qstat.full, "token pushed into a full queue")

    // A long string header opens the long-string state.
    `SVTE_ASSERT_NEXT(a_long_open_set, item.valid && item.ready && item.mode == svte_pkg::MODE_TEXT_START && item.text_length > svte_pkg::SHORT_TEXT_MAX, fstat.long_open, "long string header did not open the string")

    // The final character of a string always leaves the long-string state closed.
    `SVTE_ASSERT_NEXT(a_long_open_clear, item.valid && item.ready && item.mode == svte_pkg::MODE_TEXT_CHAR && item.final_char, !fstat.long_open, "final character left a long string open")

endmodule

// File: sv/svte_front.sv
module svte_front (
    input  logic                 clk,
    input  logic                 rst_n,
    svte_item_if.sink            item,
    input  svte_pkg::queue_stat_t qstat,
    output logic                 push,
    output svte_pkg::token_t     push_data,
    output svte_pkg::front_stat_t fstat
);

    logic               long_open_reg;
    logic               long_open_next;
    logic [30:0]        v_sat;
    logic [31:0]        z;
    logic [2:0]         ngroups;
    svte_pkg::byte_t    grp [svte_pkg::VINT_MAX_GROUPS];
    svte_pkg::token_t   tok;

    assign item.ready = !qstat.full;
    assign push       = item.valid && item.ready;
    assign push_data  = tok;
    assign fstat.long_open = long_open_reg;

    // Saturate, zigzag and split into VInt groups; the last group carries the marker.
    always_comb
    begin
        v_sat = (item.value_bits[63:31] != '0) ? svte_pkg::INT_SATURATION
                                               : item.value_bits[30:0];
        z = {v_sat, 1'b0};
        grp[0] = svte_pkg::VINT_LAST_MARK | {2'b00, z[5:0]};
        grp[1] = {1'b0, z[12:6]};
        grp[2] = {1'b0, z[19:13]};
        grp[3] = {1'b0, z[26:20]};
        grp[4] = {3'b000, z[31:27]};
        priority if (z[31:27] != '0)
            ngroups = 3'd5;
        else if (z[26:20] != '0)
            ngroups = 3'd4;
        else if (z[19:13] != '0)
            ngroups = 3'd3;
        else if (z[12:6] != '0)
            ngroups = 3'd2;
        else
            ngroups = 3'd1;
    end

    always_comb
    begin
        tok            = '0;
        long_open_next = long_open_reg;
        unique case (svte_pkg::mode_t'(item.mode))
            svte_pkg::MODE_INT:
            begin
                if (z[31:5] == '0)
                begin
                    tok.bytes[0] = svte_pkg::BYTE_SMALL_INT + z[7:0];
                    tok.count    = 4'd1;
                end
                else
                begin
                    tok.bytes[0] = svte_pkg::BYTE_VINT_PREFIX;
                    for (int j = 0; j < svte_pkg::VINT_MAX_GROUPS; j++)
                    begin
                        if (3'(j) < ngroups)
                            tok.bytes[j+1] = grp[ngroups - 3'(j) - 3'd1];
                    end
                    tok.count = {1'b0, ngroups} + 4'd1;
                end
            end
            svte_pkg::MODE_DOUBLE:
            begin
                tok.bytes[0] = svte_pkg::BYTE_DOUBLE;
                tok.bytes[1] = {7'd0, item.value_bits[63]};
                for (int k = 0; k < 9; k++)
                    tok.bytes[k+2] = {1'b0, item.value_bits[56-7*k +: 7]};
                tok.count = 4'd11;
            end
            svte_pkg::MODE_TEXT_START:
            begin
                tok.count = 4'd1;
                if (item.text_length == '0)
                begin
                    tok.bytes[0]   = svte_pkg::BYTE_TEXT_EMPTY;
                    long_open_next = 1'b0;
                end
                else if (item.text_length <= svte_pkg::SHORT_TEXT_MAX)
                begin
                    tok.bytes[0]   = svte_pkg::BYTE_TEXT_SHORT_BASE + item.text_length[7:0];
                    long_open_next = 1'b0;
                end
                else
                begin
                    tok.bytes[0]   = svte_pkg::BYTE_TEXT_LONG;
                    long_open_next = 1'b1;
                end
            end
            svte_pkg::MODE_TEXT_CHAR:
            begin
                tok.bytes[0] = item.text_byte;
                tok.count    = 4'd1;
                if (item.final_char && long_open_reg)
                begin
                    tok.bytes[1]   = svte_pkg::BYTE_TEXT_END;
                    tok.count      = 4'd2;
                    long_open_next = 1'b0;
                end
            end
            default:
            begin
                tok = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_open_reg <= 1'b0;
        else if (push)
            long_open_reg <= long_open_next;
    end

endmodule

// File: sv/svte_queue.sv
module svte_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  svte_pkg::token_t      push_data,
    input  logic                  pop,
    output svte_pkg::token_t      pop_data,
    output svte_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    svte_pkg::token_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/svte_back.sv
module svte_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  svte_pkg::token_t      head,
    input  svte_pkg::queue_stat_t qstat,
    output logic                  pop,
    svte_stream_if.source         stream
);

    logic                               cur_valid_reg, cur_valid_next;
    svte_pkg::token_t                   cur_reg;
    logic [svte_pkg::TOKEN_IDX_W-1:0]   idx_reg, idx_next;
    logic                               out_valid_reg, out_valid_next;
    svte_pkg::byte_t                    out_byte_reg;
    logic                               out_end_reg;
    logic                               advance;
    logic                               last;
    logic                               load;

    assign advance = cur_valid_reg && (!out_valid_reg || stream.ready);
    assign last    = (idx_reg == cur_reg.count - 4'd1);
    assign load    = !cur_valid_reg || (advance && last);
    assign pop     = load && !qstat.empty;

    assign stream.valid     = out_valid_reg;
    assign stream.out_byte  = out_byte_reg;
    assign stream.token_end = out_end_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = !qstat.empty;
            idx_next       = '0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 4'd1;
        end
        if (advance)
            out_valid_next = 1'b1;
        else if (stream.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (advance)
        begin
            out_byte_reg <= cur_reg.bytes[idx_reg];
            out_end_reg  <= last;
        end
    end

endmodule

// File: tb/sv/smile_value_token_encoder_core_tb.sv
`timescale 1ns / 1ps

// Testbench for the Smile value token encoder.
//
// Every value item that the encoder accepts is run through a predictor written here,
// which turns it into the bytes of its token and tracks whether a long string is open.
// The expected bytes wait in a queue. A monitor pops one for each byte transaction on
// the output channel and compares the byte and its token_end flag.
//
// Inputs change at the falling clock edge and outputs are sampled at the rising edge,
// so no check depends on the order of events within a time step.
module smile_value_token_encoder_core_tb;

    // One expected byte of the output stream, with its end-of-token flag.
    typedef struct packed {
        svte_pkg::byte_t data;
        logic            last;
    } coded_byte_t;

    // Cycles without any transaction on either channel before the run is abandoned.
    // The longest correct quiet stretch is one random stall run, which is far shorter.
    localparam int unsigned QUIET_LIMIT = 4000;

    // Cycles allowed after the last expected byte for stray bytes to show up.
    localparam int unsigned DRAIN_CYCLES = 30;

    // Number of input items that the run aims for, directed part included.
    localparam int unsigned ITEM_GOAL = 360;

    logic clk = 1'b0;
    logic rst_n;

    svte_item_if   item_ch ();
    svte_stream_if stream_ch ();

    smile_value_token_encoder_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .stream (stream_ch)
    );

    // The clock runs with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bytes that the predictor has produced and the output has not yet delivered.
    coded_byte_t expected_stream[$];

    // Predictor state: set while a string longer than 64 bytes is being sent.
    logic long_string_active;

    // Scratch space for the token being assembled by the predictor.
    svte_pkg::byte_t token_buf[svte_pkg::TOKEN_MAX_BYTES];
    int              token_len;

    // Idle percentages for the current phase of the run.
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned items_sent;
    int unsigned bytes_checked;
    int unsigned error_count;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void add_byte(input svte_pkg::byte_t b);
        token_buf[token_len] = b;
        token_len++;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Predicts the token for one accepted item and queues its bytes. The last byte of the
    // token carries the end flag.
    function automatic void encode_expected(
        input svte_pkg::mode_t m,
        input logic [63:0]     value,
        input logic [15:0]     len,
        input svte_pkg::byte_t chr,
        input logic            final_char
    );
        logic [63:0]     clamped;
        logic [31:0]     zz;
        svte_pkg::byte_t groups[svte_pkg::VINT_MAX_GROUPS];
        int              ng;
        int              s;
        coded_byte_t     cb;

        token_len = 0;
        case (m)
            svte_pkg::MODE_INT:
            begin
                // Values beyond the signed 32-bit range saturate, then zigzag for a
                // non-negative value is a plain shift left by one.
                clamped = (value > {33'd0, svte_pkg::INT_SATURATION})
                        ? {33'd0, svte_pkg::INT_SATURATION} : value;
                zz = {clamped[30:0], 1'b0};
                if (zz <= 32'h1F)
                begin
                    add_byte(svte_pkg::BYTE_SMALL_INT + svte_pkg::byte_t'(zz));
                end
                else
                begin
                    // The last VInt byte holds the marker and the low six bits; the
                    // groups above it hold seven bits each, most significant first.
                    ng = 0;
                    groups[ng] = svte_pkg::VINT_LAST_MARK | {2'b00, zz[5:0]};
                    ng++;
                    zz = zz >> 6;
                    while (zz != 0 && ng < svte_pkg::VINT_MAX_GROUPS)
                    begin
                        groups[ng] = {1'b0, zz[6:0]};
                        ng++;
                        zz = zz >> 7;
                    end
                    add_byte(svte_pkg::BYTE_VINT_PREFIX);
                    for (int j = ng - 1; j >= 0; j--)
                    begin
                        add_byte(groups[j]);
                    end
                end
            end
            svte_pkg::MODE_DOUBLE:
            begin
                // The sign bit goes out alone, then nine 7-bit groups.
                add_byte(svte_pkg::BYTE_DOUBLE);
                add_byte({7'd0, value[63]});
                for (s = 56; s >= 0; s -= 7)
                begin
                    add_byte({1'b0, value[s +: 7]});
                end
            end
            svte_pkg::MODE_TEXT_START:
            begin
                // A new header always decides the long-string flag, even when a long
                // string was still open and is abandoned without its terminator.
                if (len == 16'd0)
                begin
                    add_byte(svte_pkg::BYTE_TEXT_EMPTY);
                    long_string_active = 1'b0;
                end
                else if (len <= svte_pkg::SHORT_TEXT_MAX)
                begin
                    add_byte(svte_pkg::BYTE_TEXT_SHORT_BASE + svte_pkg::byte_t'(len));
                    long_string_active = 1'b0;
                end
                else
                begin
                    add_byte(svte_pkg::BYTE_TEXT_LONG);
                    long_string_active = 1'b1;
                end
            end
            default:
            begin
                // Characters pass through; only the last character of a long string
                // gets the terminator after it.
                add_byte(chr);
                if (final_char && long_string_active)
                begin
                    add_byte(svte_pkg::BYTE_TEXT_END);
                    long_string_active = 1'b0;
                end
            end
        endcase

        for (int i = 0; i < token_len; i++)
        begin
            cb.data = token_buf[i];
            cb.last = (i == token_len - 1);
            expected_stream.push_back(cb);
        end
    endfunction

    // Sends one item: idles at random first, then holds valid until the transaction.
    // Called and left just after a falling edge; valid stays high on return so that
    // back-to-back items need no gap.
    task automatic send_item(
        input svte_pkg::mode_t m,
        input logic [63:0]     value,
        input logic [15:0]     len,
        input svte_pkg::byte_t chr,
        input logic            final_char
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid       = 1'b0;
            item_ch.mode        = 2'($urandom);
            item_ch.value_bits  = rand64();
            item_ch.text_length = 16'($urandom);
            item_ch.text_byte   = 8'($urandom);
            item_ch.final_char  = 1'($urandom);
            @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.mode        = m;
        item_ch.value_bits  = value;
        item_ch.text_length = len;
        item_ch.text_byte   = chr;
        item_ch.final_char  = final_char;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        encode_expected(m, value, len, chr, final_char);
        items_sent++;
        @(negedge clk);
    endtask

    // Mode-specific wrappers; the fields that a mode ignores carry random junk.
    task automatic send_int(input logic [63:0] value);
        send_item(svte_pkg::MODE_INT, value, 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_double(input logic [63:0] bits);
        send_item(svte_pkg::MODE_DOUBLE, bits, 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_text_start(input logic [15:0] len);
        send_item(svte_pkg::MODE_TEXT_START, rand64(), len, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_text_char(input svte_pkg::byte_t chr, input logic final_char);
        send_item(svte_pkg::MODE_TEXT_CHAR, rand64(), 16'($urandom), chr, final_char);
    endtask

    // Receiver: decides at each falling edge whether to stall in the next cycle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stream_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output checker: every byte transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_stream
        coded_byte_t want;
        if (rst_n && stream_ch.valid && stream_ch.ready)
        begin
            if (expected_stream.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte 0x%02h token_end=%0b",
                                          stream_ch.out_byte, stream_ch.token_end));
            end
            else
            begin
                want = expected_stream.pop_front();
                bytes_checked++;
                if (stream_ch.out_byte !== want.data)
                begin
                    report_mismatch($sformatf("byte %0d: out_byte 0x%02h, expected 0x%02h",
                                              bytes_checked, stream_ch.out_byte, want.data));
                end
                if (stream_ch.token_end !== want.last)
                begin
                    report_mismatch($sformatf("byte %0d: token_end %0b, expected %0b",
                                              bytes_checked, stream_ch.token_end, want.last));
                end
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either channel means a hang.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (stream_ch.valid && stream_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Watchdog expired after %0d quiet cycles, %0d bytes still expected",
                 QUIET_LIMIT, expected_stream.size());
        $display("TB_ERROR");
        $finish;
    end

    task automatic set_idling(input int unsigned sender_pct, input int unsigned recv_pct);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
    endtask

    // Integer tokens: small-int bytes, VInt tokens of one, two and five groups, the edges of
    // the one-group length, and saturation of values above the 32-bit signed range.
    task automatic test_integer_edges();
        send_int(64'd0);
        send_int(64'd15);
        send_int(64'd16);
        send_int(64'd31);
        send_int(64'd32);
        send_int(64'd4095);
        send_int(64'h7FFF_FFFF);
        send_int(64'h8000_0000);
        send_int(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // Double tokens: all zeros, all ones, a lone sign bit and a typical value.
    task automatic test_double_edges();
        send_double(64'd0);
        send_double(64'hFFFF_FFFF_FFFF_FFFF);
        send_double(64'h8000_0000_0000_0000);
        send_double(64'h3FF0_0000_0000_0000);
    endtask

    // String headers for every length class, plus the long-string flag: a terminator
    // after the last character of a long string only, none for a short one, a character
    // outside any string, and a new header abandoning an open long string.
    task automatic test_string_flow();
        send_text_char(8'h41, 1'b1);
        send_text_start(16'd0);
        send_text_start(16'd1);
        send_text_char(8'h00, 1'b1);
        send_text_start(16'd64);
        send_text_start(16'd65);
        send_text_char(8'hFF, 1'b0);
        send_text_char(8'h7A, 1'b1);
        send_text_start(16'hFFFF);
        send_text_char(8'h55, 1'b0);
        send_text_start(16'd2);
        send_text_char(8'hAA, 1'b1);
    endtask

    // Random string: mostly lengths within the short range, some long ones across the
    // whole 16-bit field, then up to four characters, the last one flagged final if complete.
    task automatic send_random_string(input logic complete);
        int unsigned pick;
        int unsigned nchars;
        logic [15:0] len;
        pick = $urandom_range(9);
        if (pick == 0)
            len = 16'd0;
        else if (pick <= 5)
            len = 16'($urandom_range(64, 1));
        else if (pick <= 7)
            len = 16'($urandom_range(65535, 65));
        else if (pick == 8)
            len = ($urandom_range(1) != 0) ? 16'd64 : 16'd65;
        else
            len = 16'($urandom);
        send_text_start(len);
        nchars = $urandom_range(4);
        for (int unsigned i = 0; i < nchars; i++)
        begin
            send_text_char(8'($urandom), complete && (i == nchars - 1));
        end
    endtask

    // Random mix of tokens until the item count reaches the goal for this phase.
    task automatic test_random_tokens(input int unsigned goal);
        int unsigned pick;
        logic [63:0] value;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                // Integers spread over every magnitude, saturating ones included.
                case ($urandom_range(3))
                    0: value = 64'($urandom_range(15));
                    1: value = {32'd0, $urandom} >> $urandom_range(31);
                    2: value = {33'd0, 31'($urandom)};
                    default: value = rand64() >> $urandom_range(63);
                endcase
                send_int(value);
            end
            else if (pick < 40)
            begin
                send_double(rand64());
            end
            else if (pick < 85)
            begin
                send_random_string(1'b1);
            end
            else if (pick < 93)
            begin
                // A stray character with no string header in front of it.
                send_text_char(8'($urandom), 1'($urandom));
            end
            else
            begin
                // A string whose last character never arrives.
                send_random_string(1'b0);
            end
        end
    endtask

    initial
    begin
        int unsigned phase_items;

        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.mode          = svte_pkg::MODE_INT;
        item_ch.value_bits    = 64'd0;
        item_ch.text_length   = 16'd0;
        item_ch.text_byte     = 8'd0;
        item_ch.final_char    = 1'b0;
        stream_ch.ready       = 1'b0;
        long_string_active    = 1'b0;
        items_sent            = 0;
        bytes_checked         = 0;
        error_count           = 0;
        set_idling(0, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_integer_edges();
        test_double_edges();
        test_string_flow();

        // The random part runs in four phases with different idling on each side.
        phase_items = (ITEM_GOAL - items_sent) / 4;
        set_idling(0, 0);
        test_random_tokens(items_sent + phase_items);
        set_idling(61, 0);
        test_random_tokens(items_sent + phase_items);
        set_idling(0, 61);
        test_random_tokens(items_sent + phase_items);
        set_idling(32, 32);
        test_random_tokens(ITEM_GOAL);

        item_ch.valid = 1'b0;

        // Let the output drain, then give stray bytes a chance to appear.
        while (expected_stream.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (integers, doubles, string headers and characters) and",
                 items_sent);
        $display("checked %0d output bytes over four idling phases; %0d mismatches",
                 bytes_checked, error_count);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/svte_pkg.sv
sv/svte_channel_if.sv
sv/svte_front.sv
sv/svte_queue.sv
sv/svte_back.sv
sv/smile_value_token_encoder_core.sv
tb/sv/smile_value_token_encoder_core_tb.sv
